/* rtl/periodic_task_timer_table_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the periodic task timer table
// Each macro wraps one concurrent assertion clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_TASK_TIMER_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only outside reset.
`define PTTT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define PTTT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define PTTT_ASSERT(lbl, prop, msg)
`define PTTT_ASSERT_RST(lbl, prop, msg)
`endif

`endif

/* rtl/pttt_pkg.sv */
// ----------------------------------------------------------------------------
// pttt_pkg
// Types, sizes and codes shared by the periodic task timer table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pttt_pkg;

    localparam int MAX_TASKS = 16;
    localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int HANDLE_W  = 4;
    localparam int TIME_W    = 32;

    typedef enum logic [2:0] {
        ACT_ADD     = 3'd0,
        ACT_EDIT    = 3'd1,
        ACT_DELETE  = 3'd2,
        ACT_DISABLE = 3'd3,
        ACT_ENABLE  = 3'd4,
        ACT_EXECUTE = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_BAD_HANDLE = 2'd2,
        ST_NO_TASKS   = 2'd3
    } status_t;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FIRED  = 1'b1;

    typedef struct packed {
        action_t             action;
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   interval;
        logic                one_shot;
        logic [TIME_W-1:0]   time_now;
    } req_t;

    typedef struct packed {
        logic                kind;
        logic [HANDLE_W-1:0] task_slot;
        status_t             status;
        logic                last;
    } rsp_t;

endpackage

/* rtl/pttt_due_unit.sv */
// ----------------------------------------------------------------------------
// pttt_due_unit
// Shared subtract-compare: a slot is due once the wrapped time since its
// last run reaches its interval.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pttt_due_unit (
    input  logic [pttt_pkg::TIME_W-1:0] time_now,
    input  logic [pttt_pkg::TIME_W-1:0] last_run,
    input  logic [pttt_pkg::TIME_W-1:0] interval,
    output logic                        due
);

    logic [pttt_pkg::TIME_W-1:0] elapsed;

    // modulo 2^32 difference, so a wrapped tick count still works
    assign elapsed = time_now - last_run;
    assign due     = (elapsed >= interval);

endmodule

/* rtl/periodic_task_timer_table.sv */
// ----------------------------------------------------------------------------
// periodic_task_timer_table: one request at a time; add scans for a free slot
// before its status, edit/delete/enable/disable go straight to theirs, execute
// checks one slot per cycle via the shared subtract-compare, unless output stalls.
// Synchronous active-low reset empties the table at once; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "periodic_task_timer_table_defines.svh"

module periodic_task_timer_table (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  pttt_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output pttt_pkg::rsp_t  m_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_EXEC_SCAN,
        S_RESP
    } state_t;

    localparam logic [pttt_pkg::SLOT_W-1:0] LAST_IDX =
        pttt_pkg::SLOT_W'(pttt_pkg::MAX_TASKS - 1);
    localparam logic [pttt_pkg::CNT_W-1:0] FULL_CNT =
        pttt_pkg::CNT_W'(pttt_pkg::MAX_TASKS);

    state_t                            state_reg, state_next;
    pttt_pkg::req_t                    req_reg, req_next;
    pttt_pkg::rsp_t                    rsp_reg, rsp_next;
    logic [pttt_pkg::SLOT_W-1:0]       idx_reg, idx_next;
    logic [pttt_pkg::MAX_TASKS-1:0]    valid_reg, valid_next;
    logic [pttt_pkg::MAX_TASKS-1:0]    enabled_reg, enabled_next;
    logic [pttt_pkg::MAX_TASKS-1:0]    one_shot_reg, one_shot_next;
    logic [pttt_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                              m_valid_reg, m_valid_next;
    pttt_pkg::rsp_t                    m_data_reg, m_data_next;

    logic [pttt_pkg::TIME_W-1:0]       interval_mem [pttt_pkg::MAX_TASKS];
    logic [pttt_pkg::TIME_W-1:0]       last_run_mem [pttt_pkg::MAX_TASKS];
    logic [pttt_pkg::TIME_W-1:0]       rd_interval_reg;
    logic [pttt_pkg::TIME_W-1:0]       rd_last_run_reg;
    logic [pttt_pkg::SLOT_W-1:0]       rd_addr;

    logic                              ivl_we;
    logic [pttt_pkg::SLOT_W-1:0]       ivl_waddr;
    logic [pttt_pkg::TIME_W-1:0]       ivl_wdata;
    logic                              lr_we;
    logic [pttt_pkg::SLOT_W-1:0]       lr_waddr;
    logic [pttt_pkg::TIME_W-1:0]       lr_wdata;

    logic [pttt_pkg::SLOT_W-1:0]       h_idx;
    logic                              h_ok;
    logic                              out_free;
    logic                              unit_due;
    logic                              slot_due;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign h_idx = pttt_pkg::SLOT_W'(s_data.handle);
    assign h_ok  = (int'(s_data.handle) < pttt_pkg::MAX_TASKS) && valid_reg[h_idx];

    pttt_due_unit u_due (
        .time_now (req_reg.time_now),
        .last_run (rd_last_run_reg),
        .interval (rd_interval_reg),
        .due      (unit_due)
    );

    assign slot_due = valid_reg[idx_reg] && enabled_reg[idx_reg] && unit_due;

    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        rsp_next      = rsp_reg;
        idx_next      = idx_reg;
        valid_next    = valid_reg;
        enabled_next  = enabled_reg;
        one_shot_next = one_shot_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        rd_addr       = idx_reg;
        ivl_we        = 1'b0;
        ivl_waddr     = idx_reg;
        ivl_wdata     = req_reg.interval;
        lr_we         = 1'b0;
        lr_waddr      = idx_reg;
        lr_wdata      = req_reg.time_now;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                // prefetch slot 0 so an execute can compare on its first cycle
                rd_addr = '0;
                if (s_valid) begin
                    req_next           = s_data;
                    rsp_next.kind      = pttt_pkg::KIND_STATUS;
                    rsp_next.task_slot = '0;
                    rsp_next.status    = pttt_pkg::ST_OK;
                    rsp_next.last      = 1'b1;
                    state_next         = S_RESP;
                    case (s_data.action)
                        pttt_pkg::ACT_ADD: begin
                            if (cnt_reg == FULL_CNT) begin
                                rsp_next.status = pttt_pkg::ST_FULL;
                            end else begin
                                idx_next   = '0;
                                state_next = S_ADD_SCAN;
                            end
                        end
                        pttt_pkg::ACT_EDIT: begin
                            if (h_ok) begin
                                ivl_we    = 1'b1;
                                ivl_waddr = h_idx;
                                ivl_wdata = s_data.interval;
                            end else begin
                                rsp_next.status = pttt_pkg::ST_BAD_HANDLE;
                            end
                        end
                        pttt_pkg::ACT_DELETE: begin
                            if (cnt_reg == '0) begin
                                rsp_next.status = pttt_pkg::ST_NO_TASKS;
                            end else if (h_ok) begin
                                valid_next[h_idx] = 1'b0;
                                cnt_next          = cnt_reg - 1'b1;
                            end else begin
                                rsp_next.status = pttt_pkg::ST_BAD_HANDLE;
                            end
                        end
                        pttt_pkg::ACT_DISABLE, pttt_pkg::ACT_ENABLE: begin
                            if (h_ok) begin
                                enabled_next[h_idx] = (s_data.action == pttt_pkg::ACT_ENABLE);
                            end else begin
                                rsp_next.status = pttt_pkg::ST_BAD_HANDLE;
                            end
                        end
                        pttt_pkg::ACT_EXECUTE: begin
                            if (cnt_reg == '0) begin
                                rsp_next.status = pttt_pkg::ST_NO_TASKS;
                            end else begin
                                idx_next   = '0;
                                state_next = S_EXEC_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD_SCAN: begin
                if (!valid_reg[idx_reg]) begin
                    valid_next[idx_reg]    = 1'b1;
                    enabled_next[idx_reg]  = 1'b1;
                    one_shot_next[idx_reg] = req_reg.one_shot;
                    ivl_we                 = 1'b1;
                    lr_we                  = 1'b1;
                    lr_wdata               = '0;
                    cnt_next               = cnt_reg + 1'b1;
                    rsp_next.task_slot     = pttt_pkg::HANDLE_W'(idx_reg);
                    state_next             = S_RESP;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_EXEC_SCAN: begin
                // hold on a due slot until the output register frees up
                if (!slot_due || out_free) begin
                    if (slot_due) begin
                        m_valid_next           = 1'b1;
                        m_data_next.kind       = pttt_pkg::KIND_FIRED;
                        m_data_next.task_slot  = pttt_pkg::HANDLE_W'(idx_reg);
                        m_data_next.status     = pttt_pkg::ST_OK;
                        m_data_next.last       = 1'b0;
                        lr_we                  = 1'b1;
                        if (one_shot_reg[idx_reg]) begin
                            valid_next[idx_reg] = 1'b0;
                            cnt_next            = cnt_next - 1'b1;
                        end
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_next = S_RESP;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                        rd_addr  = idx_reg + 1'b1;
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = rsp_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            valid_reg   <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            valid_reg   <= valid_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg      <= req_next;
        rsp_reg      <= rsp_next;
        enabled_reg  <= enabled_next;
        one_shot_reg <= one_shot_next;
        m_data_reg   <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (ivl_we) begin
            interval_mem[ivl_waddr] <= ivl_wdata;
        end
        rd_interval_reg <= interval_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (lr_we) begin
            last_run_mem[lr_waddr] <= lr_wdata;
        end
        rd_last_run_reg <= last_run_mem[rd_addr];
    end

    `PTTT_ASSERT(a_fill_count, cnt_reg == pttt_pkg::CNT_W'($countones(valid_reg)), "fill count out of step with valid bits")
    `PTTT_ASSERT(a_add_room, (state_reg == S_ADD_SCAN) |-> (cnt_reg != FULL_CNT), "add scan started on a full table")
    `PTTT_ASSERT(a_scan_range, ((state_reg == S_ADD_SCAN) || (state_reg == S_EXEC_SCAN)) |-> (idx_reg <= LAST_IDX), "slot index beyond table")
    `PTTT_ASSERT(a_fired_shape, (m_valid_reg && (m_data_reg.kind == pttt_pkg::KIND_FIRED)) |-> (!m_data_reg.last && (m_data_reg.status == pttt_pkg::ST_OK)), "fired result carries status or last")
    `PTTT_ASSERT_RST(a_reset_idle, $past(!aresetn) |-> (!m_valid_reg && (state_reg == S_IDLE)), "block not idle after reset")

endmodule

/* verif/tb_periodic_task_timer_table.sv */
// ----------------------------------------------------------------------------
// tb_periodic_task_timer_table
// Self-checking bench for the task timer table. A queue of requests feeds a
// bursty driver; a shadow copy of the slot table predicts the status and
// fired-slot results of each accepted request, and the monitor checks every
// result against them while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_periodic_task_timer_table;

    import pttt_pkg::*;

    localparam int N_RANDOM   = 430;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_WAIT = 40;

    logic   aclk    = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    req_t   s_data  = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    rsp_t   m_data;

    periodic_task_timer_table uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow slot table
    bit          tbl_valid    [MAX_TASKS];
    bit          tbl_enabled  [MAX_TASKS];
    bit          tbl_one_shot [MAX_TASKS];
    bit [31:0]   tbl_interval [MAX_TASKS];
    bit [31:0]   tbl_last_run [MAX_TASKS];

    req_t        request_queue [$];
    rsp_t        pending_results [$];
    int          err_count    = 0;
    int          results_seen = 0;

    function automatic void push_result(logic kind, int slot, status_t st, logic last);
        rsp_t r;
        r.kind      = kind;
        r.task_slot = slot[HANDLE_W-1:0];
        r.status    = st;
        r.last      = last;
        pending_results.push_back(r);
    endfunction

    function automatic bit table_is_empty();
        for (int i = 0; i < MAX_TASKS; i++) begin
            if (tbl_valid[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit handle_live(logic [HANDLE_W-1:0] h);
        return (int'(h) < MAX_TASKS) && tbl_valid[h];
    endfunction

    // Apply one request to the shadow table and queue the results it causes.
    function automatic void table_step(req_t r);
        bit [31:0] since;
        case (r.action)
            ACT_ADD: begin
                for (int i = 0; i < MAX_TASKS; i++) begin
                    if (!tbl_valid[i]) begin
                        tbl_valid[i]    = 1'b1;
                        tbl_enabled[i]  = 1'b1;
                        tbl_one_shot[i] = r.one_shot;
                        tbl_interval[i] = r.interval;
                        tbl_last_run[i] = '0;
                        push_result(KIND_STATUS, i, ST_OK, 1'b1);
                        return;
                    end
                end
                push_result(KIND_STATUS, 0, ST_FULL, 1'b1);
            end
            ACT_EDIT, ACT_DISABLE, ACT_ENABLE: begin
                if (!handle_live(r.handle)) begin
                    push_result(KIND_STATUS, 0, ST_BAD_HANDLE, 1'b1);
                end else begin
                    if (r.action == ACT_EDIT) tbl_interval[r.handle] = r.interval;
                    else tbl_enabled[r.handle] = (r.action == ACT_ENABLE);
                    push_result(KIND_STATUS, 0, ST_OK, 1'b1);
                end
            end
            ACT_DELETE: begin
                if (table_is_empty()) begin
                    push_result(KIND_STATUS, 0, ST_NO_TASKS, 1'b1);
                end else if (!handle_live(r.handle)) begin
                    push_result(KIND_STATUS, 0, ST_BAD_HANDLE, 1'b1);
                end else begin
                    tbl_valid[r.handle] = 1'b0;
                    push_result(KIND_STATUS, 0, ST_OK, 1'b1);
                end
            end
            ACT_EXECUTE: begin
                if (table_is_empty()) begin
                    push_result(KIND_STATUS, 0, ST_NO_TASKS, 1'b1);
                end else begin
                    for (int i = 0; i < MAX_TASKS; i++) begin
                        since = r.time_now - tbl_last_run[i];
                        if (tbl_valid[i] && tbl_enabled[i] && since >= tbl_interval[i]) begin
                            tbl_last_run[i] = r.time_now;
                            push_result(KIND_FIRED, i, ST_OK, 1'b0);
                            if (tbl_one_shot[i]) tbl_valid[i] = 1'b0;
                        end
                    end
                    push_result(KIND_STATUS, 0, ST_OK, 1'b1);
                end
            end
            default: push_result(KIND_STATUS, 0, ST_OK, 1'b1);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of requests separated by random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (s_valid && s_ready) table_step(s_data);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    s_valid  <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (request_queue.size() > 0) begin
                    s_data  <= request_queue.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 20);
                        // about a third of bursts run back to back
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern re-picked at random from four modes, plus one long hold
    // ------------------------------------------------------------------
    int  rx_cycle  = 0;
    int  rx_mode   = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rx_cycle <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 64 == 63) rx_mode <= $urandom_range(0, 3);
            if (!hold_done && results_seen >= 150) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_LEN;
                m_ready   <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                case (rx_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= $urandom_range(0, 1);
                    2: m_ready <= (rx_cycle % 4 == 0);
                    default: m_ready <= ($urandom_range(0, 99) < 85);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    rsp_t want;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
                err_count <= err_count + 1;
                $display("%0t: mismatch expected no result, %s", $time,
                         $sformatf("actual kind=%0d slot=%0d status=%0d last=%0d",
                                   m_data.kind, m_data.task_slot, m_data.status,
                                   m_data.last));
            end else begin
                want = pending_results.pop_front();
                if (m_data.kind !== want.kind || m_data.task_slot !== want.task_slot ||
                    m_data.status !== want.status || m_data.last !== want.last) begin
                    err_count <= err_count + 1;
                    $display("%0t: mismatch expected kind=%0d slot=%0d status=%0d last=%0d, %s",
                             $time, want.kind, want.task_slot, want.status, want.last,
                             $sformatf("actual kind=%0d slot=%0d status=%0d last=%0d",
                                       m_data.kind, m_data.task_slot, m_data.status,
                                       m_data.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    bit [31:0] tick_now = 32'd100;

    task automatic queue_request(action_t act, int h, bit [31:0] ivl, bit once, bit [31:0] now);
        req_t r;
        r.action   = act;
        r.handle   = h[HANDLE_W-1:0];
        r.interval = ivl;
        r.one_shot = once;
        r.time_now = now;
        // keep the queue short so handle choice tracks the live table
        while (request_queue.size() >= 4) @(negedge aclk);
        request_queue.push_back(r);
    endtask

    task automatic queue_random(int add_pct, int del_pct);
        int     roll;
        int     live [$];
        int     h;
        bit [31:0] ivl;
        action_t act;
        roll = $urandom_range(0, 99);
        if (roll < add_pct) act = ACT_ADD;
        else if (roll < add_pct + del_pct) act = ACT_DELETE;
        else if (roll < add_pct + del_pct + 8) act = ACT_EDIT;
        else if (roll < add_pct + del_pct + 15) act = ACT_DISABLE;
        else if (roll < add_pct + del_pct + 22) act = ACT_ENABLE;
        else if (roll < 97) act = ACT_EXECUTE;
        else act = action_t'(3'($urandom_range(6, 7)));
        for (int i = 0; i < MAX_TASKS; i++) if (tbl_valid[i]) live.push_back(i);
        if (live.size() > 0 && $urandom_range(0, 99) < 80)
            h = live[$urandom_range(0, live.size() - 1)];
        else
            h = $urandom_range(0, 15);
        roll = $urandom_range(0, 99);
        if (roll < 60) ivl = $urandom_range(0, 40);
        else if (roll < 80) ivl = $urandom_range(0, 1000);
        else ivl = $urandom;
        if (act == ACT_EXECUTE) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) tick_now = $urandom;
            else if (roll < 7) tick_now = 32'hFFFF_FFF0 + $urandom_range(0, 15);
            else tick_now = tick_now + $urandom_range(0, 30);
        end else begin
            tick_now = tick_now;
        end
        queue_request(act, h, ivl, ($urandom_range(0, 99) < 30),
                      (act == ACT_EXECUTE) ? tick_now : $urandom);
    endtask

    initial begin
        int add_pct;
        int del_pct;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table corners
        queue_request(ACT_EXECUTE, 0, 32'd0, 1'b0, 32'd5);
        queue_request(ACT_DELETE, 3, 32'd0, 1'b0, 32'd0);
        queue_request(ACT_EDIT, 0, 32'd7, 1'b0, 32'd0);
        queue_request(ACT_DISABLE, 15, 32'd0, 1'b1, 32'hFFFF_FFFF);
        queue_request(ACT_ENABLE, 7, 32'hFFFF_FFFF, 1'b0, 32'd0);
        // populate, then exercise handles and wraparound
        queue_request(ACT_ADD, 0, 32'd0, 1'b1, 32'd0);
        queue_request(ACT_ADD, 0, 32'hFFFF_FFFF, 1'b0, 32'd0);
        queue_request(ACT_ADD, 0, 32'd10, 1'b0, 32'd0);
        queue_request(ACT_ADD, 0, 32'd3, 1'b1, 32'd0);
        queue_request(ACT_DELETE, 9, 32'd0, 1'b0, 32'd0);
        queue_request(ACT_DISABLE, 2, 32'd0, 1'b0, 32'd0);
        queue_request(ACT_EXECUTE, 0, 32'd0, 1'b0, 32'd0);
        queue_request(ACT_EXECUTE, 15, 32'd0, 1'b0, 32'hFFFF_FFFF);
        queue_request(ACT_ENABLE, 2, 32'd0, 1'b0, 32'd0);
        queue_request(ACT_EDIT, 1, 32'd0, 1'b0, 32'd0);
        queue_request(ACT_EXECUTE, 0, 32'd0, 1'b0, 32'd4);
        queue_request(action_t'(3'd6), 1, 32'd0, 1'b0, 32'd0);
        queue_request(action_t'(3'd7), 14, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        queue_request(ACT_ADD, 0, 32'd20, 1'b0, 32'd0);
        queue_request(ACT_DELETE, 1, 32'd0, 1'b0, 32'd0);
        queue_request(ACT_DELETE, 0, 32'd0, 1'b0, 32'd0);
        queue_request(ACT_DELETE, 2, 32'd0, 1'b0, 32'd0);
        queue_request(ACT_EXECUTE, 0, 32'd0, 1'b0, 32'd50);

        // fill past capacity to reach table full
        for (int i = 0; i < MAX_TASKS + 1; i++)
            queue_request(ACT_ADD, $urandom_range(0, 15), $urandom_range(0, 40),
                          $urandom_range(0, 1), $urandom);

        // rounds pick at random between filling, draining and a plain mix
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: begin add_pct = 45; del_pct = 5;  end
                    1: begin add_pct = 8;  del_pct = 35; end
                    default: begin add_pct = 20; del_pct = 15; end
                endcase
            end
            queue_random(add_pct, del_pct);
        end

        while (request_queue.size() > 0 || s_valid || pending_results.size() > 0)
            @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);

        if (err_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/pttt_pkg.sv
rtl/pttt_due_unit.sv
rtl/periodic_task_timer_table.sv
verif/tb_periodic_task_timer_table.sv
